// ===== sv/cubic_newton_root_finder_core_assert.svh =====
// Assertion macros shared by the cubic Newton root finder RTL.
// Plain text header; no dependencies.
`ifndef CUBIC_NEWTON_ROOT_FINDER_CORE_ASSERT_SVH
`define CUBIC_NEWTON_ROOT_FINDER_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define CNRF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, off during reset.
`define CNRF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Holds in the cycle after reset is high.
`define CNRF_ASSERT_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("reset check failed");

`endif

// ===== sv/cnrf_pkg.sv =====
// Shared types and codes for the cubic Newton root finder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cnrf_pkg;

   typedef enum logic [1:0] {
      ST_CONVERGED  = 2'd0,
      ST_EXACT_ZERO = 2'd1,
      ST_ZERO_DERIV = 2'd2,
      ST_LIMIT      = 2'd3
   } status_type;

   localparam logic [1:0] CSR_COEF_LINEAR    = 2'd0;
   localparam logic [1:0] CSR_COEF_CONST     = 2'd1;
   localparam logic [1:0] CSR_TOLERANCE      = 2'd2;
   localparam logic [1:0] CSR_MAX_ITERATIONS = 2'd3;

   localparam int TOL_WIDTH  = 16;
   localparam int ITER_WIDTH = 8;

   typedef struct packed {
      logic [ITER_WIDTH-1:0] iterations;
      status_type            status;
   } res_meta_type;

endpackage

`default_nettype wire

// ===== sv/cnrf_front.sv =====
// Front queue of starting guesses for the cubic Newton root finder.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module cnrf_front #(
   parameter int WORD_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [WORD_WIDTH-1:0] push_data,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       valid,
   output logic [WORD_WIDTH-1:0]      pop_data
);

   logic [WORD_WIDTH-1:0] slot_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = count_ff == 2'd2;
   assign valid    = count_ff != 2'd0;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== sv/cnrf_div.sv =====
// Bit-serial signed fixed-point divider with saturation, one quotient bit a cycle.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module cnrf_div #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [WORD_WIDTH-1:0] numer,
   input  wire logic [WORD_WIDTH-1:0] denom,
   output logic                       done,
   output logic [WORD_WIDTH-1:0]      quot
);

   localparam int QW = WORD_WIDTH + FRAC_BITS;
   localparam int CW = $clog2(QW + 1);
   localparam logic [CW-1:0] LAST = CW'(QW - 1);
   localparam logic [WORD_WIDTH-1:0] MAXS = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam logic [WORD_WIDTH-1:0] MINS = {1'b1, {(WORD_WIDTH-1){1'b0}}};

   logic [QW-1:0]         work_ff, work_in;
   logic [WORD_WIDTH-1:0] rem_ff, rem_in;
   logic [WORD_WIDTH-1:0] dm_ff, dm_in;
   logic                  neg_ff, neg_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [WORD_WIDTH:0]   trial;
   logic [WORD_WIDTH:0]   diff;
   logic [WORD_WIDTH-1:0] nm;

   always_comb begin
      nm      = numer[WORD_WIDTH-1] ? (~numer + 1'b1) : numer;
      dm_in   = dm_ff;
      neg_in  = neg_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, work_ff[QW-1]};
      diff    = trial - {1'b0, dm_ff};
      if (start) begin
         dm_in   = denom[WORD_WIDTH-1] ? (~denom + 1'b1) : denom;
         neg_in  = numer[WORD_WIDTH-1] ^ denom[WORD_WIDTH-1];
         work_in = {nm, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring step: remainder stays below the divisor, so it fits a word
         if (!diff[WORD_WIDTH]) begin
            rem_in  = diff[WORD_WIDTH-1:0];
            work_in = {work_ff[QW-2:0], 1'b1};
         end else begin
            rem_in  = trial[WORD_WIDTH-1:0];
            work_in = {work_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dm_ff   <= dm_in;
      neg_ff  <= neg_in;
   end

   assign done = done_ff;

   always_comb begin
      if (|work_ff[QW-1:WORD_WIDTH-1]) begin
         quot = neg_ff ? MINS : MAXS;
      end else begin
         quot = neg_ff ? (~work_ff[WORD_WIDTH-1:0] + 1'b1) : work_ff[WORD_WIDTH-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== sv/cnrf_engine.sv =====
// Newton iteration sequencer: shared multiplier, saturating adds, serial divider.
// Depends on cnrf_pkg, cnrf_div and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "cubic_newton_root_finder_core_assert.svh"

module cnrf_engine #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire logic [WORD_WIDTH-1:0]             in_guess,
   output logic                                   in_pop,
   input  wire logic [WORD_WIDTH-1:0]             coef_linear,
   input  wire logic [WORD_WIDTH-1:0]             coef_const,
   input  wire logic [cnrf_pkg::TOL_WIDTH-1:0]    tolerance,
   input  wire logic [cnrf_pkg::ITER_WIDTH-1:0]   max_iterations,
   output logic                                   res_valid,
   input  wire logic                              res_take,
   output logic [WORD_WIDTH-1:0]                  res_root,
   output cnrf_pkg::res_meta_type                 res_meta
);

   localparam int W = WORD_WIDTH;
   localparam logic [W-1:0] MAXS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINS = {1'b1, {(W-1){1'b0}}};

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_SQ    = 10'b0000000010,
      S_CUBE  = 10'b0000000100,
      S_PX    = 10'b0000001000,
      S_SUMF  = 10'b0000010000,
      S_CHK   = 10'b0000100000,
      S_DFCHK = 10'b0001000000,
      S_DIV   = 10'b0010000000,
      S_UPD   = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] s;
      s = {a[W-1], a} + {b[W-1], b};
      if (s[W] != s[W-1]) return s[W] ? MINS : MAXS;
      return s[W-1:0];
   endfunction

   function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] s;
      s = {a[W-1], a} - {b[W-1], b};
      if (s[W] != s[W-1]) return s[W] ? MINS : MAXS;
      return s[W-1:0];
   endfunction

   function automatic logic [W-1:0] qmul(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W-1:0]   ma, mb;
      logic [2*W-1:0] prod, m;
      logic           neg;
      ma   = a[W-1] ? (~a + 1'b1) : a;
      mb   = b[W-1] ? (~b + 1'b1) : b;
      neg  = a[W-1] ^ b[W-1];
      prod = {{W{1'b0}}, ma} * {{W{1'b0}}, mb};
      m    = prod >> FRAC_BITS;
      if (|m[2*W-1:W-1]) return neg ? MINS : MAXS;
      return neg ? (~m[W-1:0] + 1'b1) : m[W-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [W-1:0] x_ff, x_in;
   logic [W-1:0] sq_ff, sq_in;
   logic [W-1:0] cube_ff, cube_in;
   logic [W-1:0] px_ff, px_in;
   logic [W-1:0] f_ff, f_in;
   logic [W-1:0] sq2_ff, sq2_in;
   logic [W-1:0] df_ff, df_in;
   logic [W-1:0] q_ff, q_in;
   logic [cnrf_pkg::ITER_WIDTH-1:0] iter_ff, iter_in;
   cnrf_pkg::status_type stat_ff, stat_in;
   logic [W-1:0] mul_a, mul_b, mul_y;
   logic [W-1:0] xn;
   logic [W:0]   dx;
   logic [W:0]   delta;
   logic         div_start, div_done;
   logic [W-1:0] div_quot;

   // one multiplier shared by the three products of a pass
   always_comb begin
      mul_a = x_ff;
      mul_b = x_ff;
      case (state_ff)
         S_CUBE:  mul_a = sq_ff;
         S_PX:    mul_a = coef_linear;
         default: mul_a = x_ff;
      endcase
      mul_y = qmul(mul_a, mul_b);
   end

   cnrf_div #(
      .WORD_WIDTH(WORD_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .numer(f_ff),
      .denom(df_ff),
      .done (div_done),
      .quot (div_quot)
   );

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      sq_in     = sq_ff;
      cube_in   = cube_ff;
      px_in     = px_ff;
      f_in      = f_ff;
      sq2_in    = sq2_ff;
      df_in     = df_ff;
      q_in      = q_ff;
      iter_in   = iter_ff;
      stat_in   = stat_ff;
      in_pop    = 1'b0;
      div_start = 1'b0;
      xn        = sat_sub(x_ff, q_ff);
      dx        = {x_ff[W-1], x_ff} - {xn[W-1], xn};
      delta     = dx[W] ? (~dx + 1'b1) : dx;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               in_pop   = 1'b1;
               x_in     = in_guess;
               iter_in  = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            sq_in    = mul_y;
            state_in = S_CUBE;
         end
         S_CUBE: begin
            cube_in  = mul_y;
            state_in = S_PX;
         end
         S_PX: begin
            px_in    = mul_y;
            state_in = S_SUMF;
         end
         S_SUMF: begin
            f_in     = sat_add(sat_add(cube_ff, px_ff), coef_const);
            sq2_in   = sat_add(sq_ff, sq_ff);
            state_in = S_CHK;
         end
         S_CHK: begin
            if (f_ff == '0) begin
               stat_in  = cnrf_pkg::ST_EXACT_ZERO;
               state_in = S_DONE;
            end else if (iter_ff >= max_iterations) begin
               stat_in  = cnrf_pkg::ST_LIMIT;
               state_in = S_DONE;
            end else begin
               df_in    = sat_add(sat_add(sq2_ff, sq_ff), coef_linear);
               state_in = S_DFCHK;
            end
         end
         S_DFCHK: begin
            if (df_ff == '0) begin
               stat_in  = cnrf_pkg::ST_ZERO_DERIV;
               state_in = S_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               q_in     = div_quot;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            x_in    = xn;
            iter_in = iter_ff + 1'b1;
            if (delta <= {{(W+1-cnrf_pkg::TOL_WIDTH){1'b0}}, tolerance}) begin
               stat_in  = cnrf_pkg::ST_CONVERGED;
               state_in = S_DONE;
            end else begin
               state_in = S_SQ;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      sq_ff   <= sq_in;
      cube_ff <= cube_in;
      px_ff   <= px_in;
      f_ff    <= f_in;
      sq2_ff  <= sq2_in;
      df_ff   <= df_in;
      q_ff    <= q_in;
      stat_ff <= stat_in;
   end

   assign res_valid           = state_ff == S_DONE;
   assign res_root            = x_ff;
   assign res_meta.iterations = iter_ff;
   assign res_meta.status     = stat_ff;

   `CNRF_ASSERT_IMPL(a_iter_bound, clock, reset, state_ff != S_IDLE, iter_ff <= max_iterations)
   `CNRF_ASSERT_IMPL(a_div_nonzero, clock, reset, div_start, df_ff != '0)
   `CNRF_ASSERT_IMPL(a_limit_count, clock, reset,
      res_valid && stat_ff == cnrf_pkg::ST_LIMIT, iter_ff == max_iterations)

endmodule

`default_nettype wire

// ===== sv/cubic_newton_root_finder_core.sv =====
// Cubic Newton root finder: x^3 + p*x + q solved from a starting guess per item.
// Each item runs serial passes of three products, sums, checks and the one-bit-a-cycle
// divider (default format Q16.16), one per update; up to 255 updates per item. Guesses
// queue two deep ahead of the engine, and one finished item waits in the result register.
// Depends on cnrf_pkg, cnrf_front, cnrf_engine and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "cubic_newton_root_finder_core_assert.svh"

module cubic_newton_root_finder_core #(
   parameter int WORD_WIDTH = 32,   // signed fixed-point word, 16..64
   parameter int FRAC_BITS  = 16    // fraction bits, 8..30
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // item input queue
   input  wire logic                                push,
   output logic                                     full,
   input  wire logic [WORD_WIDTH-1:0]               req_initial_guess,
   // result queue
   output logic                                     empty,
   input  wire logic                                pop,
   output logic [WORD_WIDTH-1:0]                    rsp_root,
   output logic [cnrf_pkg::ITER_WIDTH-1:0]          rsp_iterations,
   output logic [1:0]                               rsp_status,
   // register writes
   input  wire logic                                csr_we,
   input  wire logic [1:0]                          csr_index,
   input  wire logic [WORD_WIDTH-1:0]               csr_wdata
);

   localparam int W = WORD_WIDTH;
   localparam logic [64:0] MAXMAG  = (65'd1 << (W - 1)) - 65'd1;
   localparam logic [64:0] LIN_MAG = 65'd5 << FRAC_BITS;
   localparam logic [64:0] CON_MAG = 65'd3 << FRAC_BITS;
   localparam logic [W-1:0] MAXS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINS = {1'b1, {(W-1){1'b0}}};
   // p = -5.0 and q = 3.0, clamped where the word cannot hold them
   localparam logic [W-1:0] LIN_RST = (LIN_MAG > MAXMAG) ? MINS : W'(~LIN_MAG + 65'd1);
   localparam logic [W-1:0] CON_RST = (CON_MAG > MAXMAG) ? MAXS : W'(CON_MAG);
   // 0.02 rounded to the fraction grid
   localparam logic [64:0] TOL_RAW = ((65'd1 << (FRAC_BITS + 1)) + 65'd50) / 65'd100;
   localparam logic [cnrf_pkg::TOL_WIDTH-1:0] TOL_RST =
      (TOL_RAW > 65'hFFFF) ? '1 : TOL_RAW[cnrf_pkg::TOL_WIDTH-1:0];
   localparam logic [cnrf_pkg::ITER_WIDTH-1:0] ITER_RST = 8'd64;

   logic [W-1:0]                    coef_linear_ff;
   logic [W-1:0]                    coef_const_ff;
   logic [cnrf_pkg::TOL_WIDTH-1:0]  tolerance_ff;
   logic [cnrf_pkg::ITER_WIDTH-1:0] max_iter_ff;

   logic                   fq_valid, fq_pop;
   logic [W-1:0]           fq_guess;
   logic                   res_valid, res_take;
   logic [W-1:0]           res_root;
   cnrf_pkg::res_meta_type res_meta;

   logic                   out_valid_ff, out_valid_in;
   logic [W-1:0]           out_root_ff;
   cnrf_pkg::res_meta_type out_meta_ff;

   // register file; a write lands whenever csr_we is high, so write only while idle
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_linear_ff <= LIN_RST;
         coef_const_ff  <= CON_RST;
         tolerance_ff   <= TOL_RST;
         max_iter_ff    <= ITER_RST;
      end else if (csr_we) begin
         case (csr_index)
            cnrf_pkg::CSR_COEF_LINEAR:    coef_linear_ff <= csr_wdata;
            cnrf_pkg::CSR_COEF_CONST:     coef_const_ff  <= csr_wdata;
            cnrf_pkg::CSR_TOLERANCE:      tolerance_ff   <= csr_wdata[cnrf_pkg::TOL_WIDTH-1:0];
            cnrf_pkg::CSR_MAX_ITERATIONS: max_iter_ff    <= csr_wdata[cnrf_pkg::ITER_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // front: accepts guesses into a short queue
   cnrf_front #(
      .WORD_WIDTH(WORD_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(req_initial_guess),
      .full     (full),
      .pop      (fq_pop),
      .valid    (fq_valid),
      .pop_data (fq_guess)
   );

   // back: Newton iterations
   cnrf_engine #(
      .WORD_WIDTH(WORD_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (fq_valid),
      .in_guess      (fq_guess),
      .in_pop        (fq_pop),
      .coef_linear   (coef_linear_ff),
      .coef_const    (coef_const_ff),
      .tolerance     (tolerance_ff),
      .max_iterations(max_iter_ff),
      .res_valid     (res_valid),
      .res_take      (res_take),
      .res_root      (res_root),
      .res_meta      (res_meta)
   );

   // result register: engine hands over when the slot is free or being drained
   assign res_take = res_valid && (!out_valid_ff || pop);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop && out_valid_ff) out_valid_in = 1'b0;
      if (res_take)            out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         out_root_ff <= res_root;
         out_meta_ff <= res_meta;
      end
   end

   assign empty          = !out_valid_ff;
   assign rsp_root       = out_root_ff;
   assign rsp_iterations = out_meta_ff.iterations;
   assign rsp_status     = out_meta_ff.status;

   `CNRF_ASSERT_IMPL(a_take_slot, clock, reset, res_take, !out_valid_ff || pop)
   `CNRF_ASSERT_NEXT(a_take_fills, clock, reset, res_take, out_valid_ff)
   `CNRF_ASSERT_RESET(a_reset_empty, clock, reset, empty)

endmodule

`default_nettype wire
